>>> src/keyed_value_table_defines.svh
// ----------------------------------------------------------------------------
// keyed_value_table_defines
// Assertion macros used by the keyed value table RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_VALUE_TABLE_DEFINES_SVH
`define KEYED_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_value_table check failed");

// Next-cycle implication, checked outside reset
`define KVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_value_table check failed");

`endif

>>> src/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Sizes, codes and shared types of the keyed value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_WIDTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 2;
  localparam int FIELD_CNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_GET    = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  // Entry RAM access for one cycle
  typedef struct packed {
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_value;
  } mem_req_t;

  // One finished result
  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [FIELD_CNT_W-1:0] match_count;
    logic [FIELD_CNT_W-1:0] entries_used;
  } result_t;

endpackage

>>> src/kvt_entry_ram.sv
// ----------------------------------------------------------------------------
// kvt_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_entry_ram (
  input  logic                                clk,
  input  kvt_pkg::mem_req_t                   req,
  output logic [kvt_pkg::KEY_WIDTH-1:0]       rd_key,
  output logic [kvt_pkg::VALUE_WIDTH-1:0]     rd_value
);

  logic [kvt_pkg::KEY_WIDTH+kvt_pkg::VALUE_WIDTH-1:0] mem [kvt_pkg::TABLE_DEPTH];
  logic [kvt_pkg::KEY_WIDTH+kvt_pkg::VALUE_WIDTH-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_key, req.wr_value};
    end
  end

  // Read one entry into the registered read data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_key   = rd_data_r[kvt_pkg::KEY_WIDTH+kvt_pkg::VALUE_WIDTH-1:kvt_pkg::VALUE_WIDTH];
  assign rd_value = rd_data_r[kvt_pkg::VALUE_WIDTH-1:0];

endmodule

>>> src/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Command sequencer: scans the entry RAM, appends, shifts on erase and
// builds the result of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kvt_pkg::CMD_W-1:0]           in_command,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]       in_key,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0]     in_value,
  input  logic                                slot_free,
  output logic                                res_valid,
  output kvt_pkg::result_t                    res,
  output kvt_pkg::mem_req_t                   mem_req,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]       rd_key,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0]     rd_value
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [kvt_pkg::CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [kvt_pkg::KEY_WIDTH-1:0]     key_r, key_nxt;
  logic [kvt_pkg::VALUE_WIDTH-1:0]   val_r, val_nxt;
  logic [kvt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [kvt_pkg::CNT_W-1:0]         issue_r, issue_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [kvt_pkg::IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                              hit_r, hit_nxt;
  logic [kvt_pkg::IDX_W-1:0]         hit_pos_r, hit_pos_nxt;
  logic [kvt_pkg::VALUE_WIDTH-1:0]   hit_val_r, hit_val_nxt;
  logic [kvt_pkg::CNT_W-1:0]         match_r, match_nxt;
  logic [kvt_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic                              more_rd;
  logic                              pipe_empty;

  assign in_ready   = (state_r == S_IDLE);
  assign more_rd    = (issue_r < cnt_r);
  assign pipe_empty = !more_rd && !rd_vld_r;

  // Sequencer and datapath
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    issue_nxt   = issue_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    hit_nxt     = hit_r;
    hit_pos_nxt = hit_pos_r;
    hit_val_nxt = hit_val_r;
    match_nxt   = match_r;
    status_nxt  = status_r;
    mem_req     = '0;
    res_valid   = 1'b0;
    res         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          key_nxt    = in_key;
          val_nxt    = in_value;
          issue_nxt  = '0;
          hit_nxt    = 1'b0;
          match_nxt  = '0;
          status_nxt = kvt_pkg::ST_OK;
          case (in_command)
            kvt_pkg::CMD_INSERT: begin
              if (cnt_r == kvt_pkg::CNT_W'(kvt_pkg::TABLE_DEPTH)) begin
                status_nxt = kvt_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            kvt_pkg::CMD_ERASE, kvt_pkg::CMD_GET, kvt_pkg::CMD_COUNT: begin
              state_nxt = S_SCAN;
            end
            kvt_pkg::CMD_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read of the live range
        if (more_rd) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = issue_r[kvt_pkg::IDX_W-1:0];
          issue_nxt       = issue_r + kvt_pkg::CNT_W'(1);
          rd_vld_nxt      = 1'b1;
          rd_idx_nxt      = issue_r[kvt_pkg::IDX_W-1:0];
        end
        // Compare the entry that came back
        if (rd_vld_r) begin
          if (rd_key == key_r) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = rd_idx_r;
            hit_val_nxt = rd_value;
          end
          if (rd_value == val_r) begin
            match_nxt = match_r + kvt_pkg::CNT_W'(1);
          end
        end
        // Scan finished: decide
        if (pipe_empty) begin
          state_nxt = S_DONE;
          case (cmd_r)
            kvt_pkg::CMD_INSERT: begin
              if (hit_r) begin
                status_nxt = kvt_pkg::ST_DUPLICATE;
              end else begin
                mem_req.wr_en    = 1'b1;
                mem_req.wr_addr  = cnt_r[kvt_pkg::IDX_W-1:0];
                mem_req.wr_key   = key_r;
                mem_req.wr_value = val_r;
                cnt_nxt          = cnt_r + kvt_pkg::CNT_W'(1);
              end
            end
            kvt_pkg::CMD_ERASE: begin
              if (hit_r) begin
                issue_nxt = kvt_pkg::CNT_W'(hit_pos_r) + kvt_pkg::CNT_W'(1);
                state_nxt = S_SHIFT;
              end else begin
                status_nxt = kvt_pkg::ST_NOT_FOUND;
              end
            end
            kvt_pkg::CMD_GET: begin
              if (!hit_r) begin
                status_nxt = kvt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Read the entry above the gap
        if (more_rd) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = issue_r[kvt_pkg::IDX_W-1:0];
          issue_nxt       = issue_r + kvt_pkg::CNT_W'(1);
          rd_vld_nxt      = 1'b1;
          rd_idx_nxt      = issue_r[kvt_pkg::IDX_W-1:0];
        end
        // Move it down by one
        if (rd_vld_r) begin
          mem_req.wr_en    = 1'b1;
          mem_req.wr_addr  = rd_idx_r - kvt_pkg::IDX_W'(1);
          mem_req.wr_key   = rd_key;
          mem_req.wr_value = rd_value;
        end
        if (pipe_empty) begin
          cnt_nxt   = cnt_r - kvt_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over once the output slot is free
        if (slot_free) begin
          res_valid        = 1'b1;
          res.status       = status_r;
          res.value_out    = (cmd_r == kvt_pkg::CMD_GET && hit_r) ? hit_val_r : '0;
          res.match_count  = (cmd_r == kvt_pkg::CMD_COUNT) ?
                             kvt_pkg::FIELD_CNT_W'(match_r) : '0;
          res.entries_used = kvt_pkg::FIELD_CNT_W'(cnt_r);
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    issue_r   <= issue_nxt;
    rd_idx_r  <= rd_idx_nxt;
    hit_r     <= hit_nxt;
    hit_pos_r <= hit_pos_nxt;
    hit_val_r <= hit_val_nxt;
    match_r   <= match_nxt;
    status_r  <= status_nxt;
  end

endmodule

>>> src/keyed_value_table.sv
// ----------------------------------------------------------------------------
// keyed_value_table
// Table of unique keys with values, packed in insertion order in one
// entry RAM: insert, erase, get, count by value and clear.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Direction
// in        in_valid/in_ready, in_command/key/value      request in
// out       out_valid/out_ready, out_status/value_out/   result out
//           out_match_count/out_entries_used
//
// One request at a time. Insert, erase, get and count scan the live entries
// one RAM read per cycle; clear, unknown commands and an insert into a full
// table skip the scan. Erase then shifts the later entries down by one place.
// The single read port of the entry RAM sets the pace.
// Reset empties the table at once; the RAM is never cleared. A result waiting
// on out_ready holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_value_table_defines.svh"

module keyed_value_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kvt_pkg::CMD_W-1:0]           in_command,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]       in_key,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0]     in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kvt_pkg::STAT_W-1:0]          out_status,
  output logic [kvt_pkg::VALUE_WIDTH-1:0]     out_value_out,
  output logic [kvt_pkg::FIELD_CNT_W-1:0]     out_match_count,
  output logic [kvt_pkg::FIELD_CNT_W-1:0]     out_entries_used
);

  kvt_pkg::mem_req_t                mem_req;
  kvt_pkg::result_t                 res;
  kvt_pkg::result_t                 out_res_r;
  logic                             res_valid;
  logic                             slot_free;
  logic                             out_valid_r;
  logic [kvt_pkg::KEY_WIDTH-1:0]    rd_key;
  logic [kvt_pkg::VALUE_WIDTH-1:0]  rd_value;

  assign slot_free = !out_valid_r || out_ready;

  kvt_entry_ram u_ram (
    .clk      (clk),
    .req      (mem_req),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  kvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_key     (in_key),
    .in_value   (in_value),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_req    (mem_req),
    .rd_key     (rd_key),
    .rd_value   (rd_value)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_value_out    = out_res_r.value_out;
  assign out_match_count  = out_res_r.match_count;
  assign out_entries_used = out_res_r.entries_used;

  // Never overwrite a result still waiting
  `KVT_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_valid, slot_free)
  // Busy right after taking a request
  `KVT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // A full report only comes from a full table
  `KVT_ASSERT_IMP(a_full_count, clk, rst_n, res_valid && res.status == kvt_pkg::ST_FULL, res.entries_used == kvt_pkg::FIELD_CNT_W'(kvt_pkg::TABLE_DEPTH))
  // A result never appears while a request can be taken
  `KVT_ASSERT_IMP(a_result_not_idle, clk, rst_n, res_valid, !in_ready)

endmodule
